FILE: rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and helpers shared by the odometry/heading fusion block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES     = 30;
  localparam int unsigned MID_DEPTH        = 4;

  localparam logic [31:0] KINV_Q32    = 32'd2608131496;
  localparam logic [16:0] FULL_WEIGHT = 17'd65536;
  localparam logic [16:0] WEIGHT_RST  = 17'd32768;
  // multiple of one turn (360 deg in 2^-17 deg units) that makes the mid heading positive
  localparam logic [39:0] TURN_OFFSET = 40'd68749885440;
  localparam logic [18:0] RECIP_45    = 19'd372828;
  localparam logic [5:0]  DIV_BASE    = 6'd45;

  localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [1:0] {
    CFG_ODOMETRY_WEIGHT   = 2'd0,
    CFG_DISTANCE_PER_TICK = 2'd1,
    CFG_HEADING_PER_TICK  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] left_tick_change;
    logic signed [15:0] right_tick_change;
    logic signed [31:0] imu_yaw_change;
    logic signed [31:0] previous_heading;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_heading;
  } out_word_t;

  typedef struct packed {
    logic signed [48:0] x;
    logic signed [31:0] z;
    logic signed [31:0] dh;
  } mid_word_t;

  // floor(v / 45), exact for v below 2^18
  function automatic logic [12:0] div45(input logic [17:0] v);
    logic [36:0] p;
    p = 37'(v) * 37'(RECIP_45);
    return p[36:24];
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'h7fff_ffff;
    if (v < -48'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/ddo_fifo.sv
// ----------------------------------------------------------------------------
// ddo_fifo
// Short word queue between the front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module ddo_fifo import ddo_pkg::*; #(
  parameter int unsigned DEPTH = MID_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mid_word_t wdata_i,
  output logic      full_o,
  input  logic      pop_i,
  output mid_word_t rdata_o,
  output logic      empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mid_word_t       mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("front pushed into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("back popped empty queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a word");

endmodule

FILE: rtl/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front
// Config registers, travel and fused heading, mid angle to binary turn,
// half-plane fold. Emits start vector and angle words to the queue.
// ----------------------------------------------------------------------------
module ddo_front import ddo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  in_word_t    in_word_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output mid_word_t   out_word_o,
  input  logic        out_ready_i
);

  localparam int unsigned NDIG = 4;

  logic [16:0] weight_q;
  logic [31:0] dpt_q, hpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
      dpt_q    <= '0;
      hpt_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ODOMETRY_WEIGHT:   weight_q <= cfg_data_i[16:0];
        CFG_DISTANCE_PER_TICK: dpt_q    <= cfg_data_i;
        CFG_HEADING_PER_TICK:  hpt_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic        adv;
  logic        v1_q, v2_q, v3_q, v4_q, vo_q;
  logic [NDIG-1:0] dv_q;

  assign adv         = !vo_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vo_q;

  // stage 1: tick products
  logic signed [16:0] sum_c, dif_c;
  logic signed [49:0] s1_q, or1_q;
  logic signed [31:0] imu1_q, th1_q;

  assign sum_c = 17'(in_word_i.left_tick_change) + 17'(in_word_i.right_tick_change);
  assign dif_c = 17'(in_word_i.right_tick_change) - 17'(in_word_i.left_tick_change);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= sum_c * $signed({1'b0, dpt_q});
      or1_q  <= dif_c * $signed({1'b0, hpt_q});
      imu1_q <= in_word_i.imu_yaw_change;
      th1_q  <= in_word_i.previous_heading;
    end
  end

  // stage 2: weighting and start vector products
  logic [16:0]        w_c, wc_c;
  logic signed [33:0] odo_c;
  logic signed [49:0] orr_c;
  logic [47:0]        amag_c;
  logic signed [51:0] p1_q;
  logic signed [49:0] p2_q;
  logic [47:0]        skhi_q;
  logic [63:0]        sklo_q;
  logic               neg2_q;
  logic signed [31:0] th2_q;

  assign w_c    = (weight_q > FULL_WEIGHT) ? FULL_WEIGHT : weight_q;
  assign wc_c   = FULL_WEIGHT - w_c;
  assign orr_c  = (or1_q + 50'sd32768) >>> 16;
  assign odo_c  = orr_c[33:0];
  assign amag_c = s1_q[49] ? 48'(-s1_q) : s1_q[47:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q   <= $signed({1'b0, w_c}) * odo_c;
      p2_q   <= $signed({1'b0, wc_c}) * imu1_q;
      skhi_q <= 48'(amag_c[47:32]) * 48'(KINV_Q32);
      sklo_q <= 64'(amag_c[31:0]) * 64'(KINV_Q32);
      neg2_q <= s1_q[49];
      th2_q  <= th1_q;
    end
  end

  // stage 3: fused heading, scaled start vector
  logic signed [52:0] fsum_c;
  logic [47:0]        mag_c;
  logic signed [36:0] fused3_q;
  logic signed [48:0] x3_q;
  logic signed [31:0] th3_q;

  assign fsum_c = (53'(p1_q) + 53'(p2_q) + 53'sd32768) >>> 16;
  assign mag_c  = skhi_q + sklo_q[63:32];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fused3_q <= fsum_c[36:0];
      x3_q     <= neg2_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
      th3_q    <= th2_q;
    end
  end

  // stage 4: mid heading, made positive
  logic signed [39:0] mid_c;
  logic [39:0]        m4_q;
  logic signed [48:0] x4_q;
  logic signed [31:0] dh4_q;

  assign mid_c = 40'(th3_q) + 40'(th3_q) + 40'(fused3_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4_q  <= mid_c + TURN_OFFSET;
      x4_q  <= x3_q;
      dh4_q <= sat_s32(48'(fused3_q));
    end
  end

  // digit stages: divide by 45, ten bits a stage
  logic [39:0]        dm_q  [NDIG];
  logic [5:0]         drem_q[NDIG];
  logic [19:0]        dq_q  [NDIG];
  logic signed [48:0] dx_q  [NDIG];
  logic signed [31:0] ddh_q [NDIG];

  for (genvar k = 0; k < NDIG; k++) begin : g_dig
    logic [39:0]        m_in;
    logic [5:0]         r_in;
    logic [19:0]        q_in;
    logic signed [48:0] x_in;
    logic signed [31:0] dh_in;
    logic [15:0]        v;
    logic [12:0]        qd;
    logic [15:0]        r_full;

    if (k == 0) begin : g_first
      assign m_in  = m4_q;
      assign r_in  = '0;
      assign q_in  = '0;
      assign x_in  = x4_q;
      assign dh_in = dh4_q;
    end else begin : g_next
      assign m_in  = dm_q[k-1];
      assign r_in  = drem_q[k-1];
      assign q_in  = dq_q[k-1];
      assign x_in  = dx_q[k-1];
      assign dh_in = ddh_q[k-1];
    end

    assign v      = {r_in, m_in[39-10*k -: 10]};
    assign qd     = div45(18'(v));
    assign r_full = v - 16'(qd) * 16'(DIV_BASE);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dm_q[k]   <= m_in;
        drem_q[k] <= r_full[5:0];
        dq_q[k]   <= {q_in[9:0], qd[9:0]};
        dx_q[k]   <= x_in;
        ddh_q[k]  <= dh_in;
      end
    end
  end

  // fold: binary angle and back half-plane
  logic [12:0]        t_c;
  logic [31:0]        ang_c;
  logic               fold_c;
  mid_word_t          o_q;

  assign t_c    = div45({drem_q[NDIG-1], 12'd0} + 18'd22);
  assign ang_c  = {dq_q[NDIG-1], t_c[11:0]};
  assign fold_c = ang_c[31] ^ ang_c[30];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q.x  <= fold_c ? -dx_q[NDIG-1] : dx_q[NDIG-1];
      o_q.z  <= $signed({ang_c[31] ^ fold_c, ang_c[30:0]});
      o_q.dh <= ddh_q[NDIG-1];
    end
  end

  assign out_word_o = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      dv_q <= '0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      dv_q <= {dv_q[NDIG-2:0], v4_q};
      vo_q <= dv_q[NDIG-1];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !out_ready_i) |=> (vo_q && $stable(o_q)))
    else $error("front output changed while stalled");
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[NDIG-1] |-> (drem_q[NDIG-1] < DIV_BASE))
    else $error("digit remainder out of range");
  a_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (o_q.z[31] == o_q.z[30])) else $error("angle not folded");

endmodule

FILE: rtl/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back
// Pipelined rotation CORDIC, rounding and saturation to the result register.
// ----------------------------------------------------------------------------
module ddo_back import ddo_pkg::*; #(
  parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_empty_i,
  input  mid_word_t in_word_i,
  output logic      in_pop_o,
  output logic      empty_o,
  output out_word_t out_word_o,
  input  logic      pop_i
);

  localparam int unsigned XW = 51;
  localparam int unsigned ZW = 34;

  logic adv;
  logic [STEPS-1:0]   v_q;
  logic signed [XW-1:0] x_q [STEPS];
  logic signed [XW-1:0] y_q [STEPS];
  logic signed [ZW-1:0] z_q [STEPS];
  logic signed [31:0]   dh_q[STEPS];
  logic                 vo_q;
  out_word_t            o_q;

  assign adv      = !vo_q || pop_i;
  assign in_pop_o = adv && !in_empty_i;
  assign empty_o  = !vo_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_it
    logic                 vi;
    logic signed [XW-1:0] xi, yi, xs, ys;
    logic signed [ZW-1:0] zi, at;
    logic signed [31:0]   dhi;

    if (k == 0) begin : g_first
      assign vi  = !in_empty_i;
      assign xi  = XW'(in_word_i.x);
      assign yi  = '0;
      assign zi  = ZW'(in_word_i.z);
      assign dhi = in_word_i.dh;
    end else begin : g_next
      assign vi  = v_q[k-1];
      assign xi  = x_q[k-1];
      assign yi  = y_q[k-1];
      assign zi  = z_q[k-1];
      assign dhi = dh_q[k-1];
    end

    assign xs = xi >>> k;
    assign ys = yi >>> k;
    assign at = $signed({{(ZW-32){1'b0}}, ATAN_TURN[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv) begin
        v_q[k] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!zi[ZW-1]) begin
          x_q[k] <= xi - ys;
          y_q[k] <= yi + xs;
          z_q[k] <= zi - at;
        end else begin
          x_q[k] <= xi + ys;
          y_q[k] <= yi - xs;
          z_q[k] <= zi + at;
        end
        dh_q[k] <= dhi;
      end
    end
  end

  logic signed [XW-1:0] xr_c, yr_c;

  assign xr_c = (x_q[STEPS-1] + XW'(256)) >>> 9;
  assign yr_c = (y_q[STEPS-1] + XW'(256)) >>> 9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= v_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q.delta_x       <= sat_s32(xr_c[47:0]);
      o_q.delta_y       <= sat_s32(yr_c[47:0]);
      o_q.delta_heading <= dh_q[STEPS-1];
    end
  end

  assign out_word_o = o_q;

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !pop_i) |=> (v_q == $past(v_q)))
    else $error("pipeline moved during stall");
  a_pop_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |=> v_q[0]) else $error("popped word not in first stage");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v_q[STEPS-1]) |=> vo_q) else $error("result lost at output");

endmodule

FILE: rtl/diff_drive_odometry_imu_fusion.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_imu_fusion
// Differential-drive odometry step with complementary IMU heading blend.
//
//   channel   ports                               dir  word
//   input     push / full / in_word_i             in   in_word_t
//   result    empty / pop / out_word_o            out  out_word_t
//   config    cfg_we_i / cfg_idx_i / cfg_data_i   in   32-bit register write
//
// One word per cycle sustained while neither side stalls. A word accepted
// into the first front stage reaches the result ports through 8 more front
// stages, one queue slot, CORDIC_STEPS CORDIC stages and the result register.
// Front and back stall independently behind a 4-word queue; a stalled
// result stalls only the CORDIC pipeline until the queue fills.
// Reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry_imu_fusion import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word_i,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word_o
);

  logic      f_ready, f_valid, q_full, q_empty, q_pop;
  mid_word_t f_word, q_word;

  assign full = !f_ready;

  ddo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (push),
    .in_word_i   (in_word_i),
    .in_ready_o  (f_ready),
    .out_valid_o (f_valid),
    .out_word_o  (f_word),
    .out_ready_i (!q_full)
  );

  ddo_fifo #(
    .DEPTH (MID_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && !q_full),
    .wdata_i (f_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_word),
    .empty_o (q_empty)
  );

  ddo_back #(
    .STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (q_empty),
    .in_word_i  (q_word),
    .in_pop_o   (q_pop),
    .empty_o    (empty),
    .out_word_o (out_word_o),
    .pop_i      (pop)
  );

endmodule
